// ===== rtl/hfl_pkg.sv =====
// ---------------------------------------------------------------------------
// hfl_pkg: shared types and constants for the fairshare level factor unit
// Bucket tables, 2^-(2^-k) constants and the sideband record of the chain.
// ---------------------------------------------------------------------------
package hfl_pkg;

  // Per-level bucket width and leftover bits, indexed by level count 0..64
  typedef logic [64:0][6:0] lv_tab_t;

  // Sideband that rides along with every transaction through the chain
  typedef struct packed {
    logic [63:0] parent;   // parent word
    logic        contrib;  // this level contributes a factor
    logic [5:0]  sh;       // bucket shift
    logic [63:0] m;        // all-ones bucket value minus one
  } side_t;

  function automatic lv_tab_t make_width_tab();
    lv_tab_t t;
    int      r;
    int      w;
    t = '0;
    for (int lv = 1; lv <= 64; lv++) begin
      r = 64;
      w = 0;
      for (int j = 0; j < 64; j++) begin
        if (r >= lv) begin
          r = r - lv;
          w = w + 1;
        end
      end
      t[lv] = 7'(w);
    end
    return t;
  endfunction

  function automatic lv_tab_t make_spare_tab();
    lv_tab_t t;
    int      r;
    t = '0;
    for (int lv = 1; lv <= 64; lv++) begin
      r = 64;
      for (int j = 0; j < 64; j++) begin
        if (r >= lv) r = r - lv;
      end
      t[lv] = 7'(r);
    end
    return t;
  endfunction

  localparam lv_tab_t WIDTH_TAB = make_width_tab();
  localparam lv_tab_t SPARE_TAB = make_spare_tab();

  // Integer square root, bit by bit (elaboration only)
  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] b;
    x   = x_in;
    res = '0;
    b   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + b) begin
        x   = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // c_k ~ 2^-(2^-k) in Q0.32
  function automatic logic [31:0] pow_const(input int k);
    logic [63:0] c;
    c = isqrt64(64'd1 << 63);
    for (int j = 1; j < 32; j++) begin
      if (j < k) c = isqrt64(c << 32);
    end
    return c[31:0];
  endfunction

endpackage

// ===== rtl/hfl_div_cell.sv =====
// ---------------------------------------------------------------------------
// hfl_div_cell: one restoring-division cell
// Brings in one numerator bit, trial-subtracts the divisor, emits one
// quotient bit and hands everything to the next cell.
// ---------------------------------------------------------------------------
module hfl_div_cell
  import hfl_pkg::*;
#(
  parameter int DEN_W = 22,
  parameter int Q_W   = 37
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             v_i,
  input  side_t            side_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [Q_W-1:0]   num_i,
  input  logic [Q_W-1:0]   q_i,
  output logic             v_o,
  output side_t            side_o,
  output logic [DEN_W-1:0] den_o,
  output logic [DEN_W-1:0] rem_o,
  output logic [Q_W-1:0]   num_o,
  output logic [Q_W-1:0]   q_o
);

  logic [DEN_W:0] cand;
  logic           ge;
  logic [DEN_W:0] diff;

  // trial subtract
  assign cand = {rem_i, num_i[Q_W-1]};
  assign ge   = cand >= {1'b0, den_i};
  assign diff = cand - {1'b0, den_i};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_o <= side_i;
      den_o  <= den_i;
      rem_o  <= ge ? diff[DEN_W-1:0] : cand[DEN_W-1:0];
      num_o  <= {num_i[Q_W-2:0], 1'b0};
      q_o    <= {q_i[Q_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/hfl_pow_cell.sv =====
// ---------------------------------------------------------------------------
// hfl_pow_cell: one exponent cell
// For its ratio fraction bit, multiplies the running 2^-x by its constant.
// ---------------------------------------------------------------------------
module hfl_pow_cell
  import hfl_pkg::*;
#(
  parameter int K = 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        v_i,
  input  side_t       side_i,
  input  logic [31:0] frac_i,
  input  logic [5:0]  n_i,
  input  logic        big_i,
  input  logic [32:0] acc_i,
  output logic        v_o,
  output side_t       side_o,
  output logic [31:0] frac_o,
  output logic [5:0]  n_o,
  output logic        big_o,
  output logic [32:0] acc_o
);

  localparam logic [31:0] C   = pow_const(K);
  localparam int          BIT = 32 - K;

  logic [64:0] prod;

  assign prod = 65'(acc_i) * 65'(C);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_o <= side_i;
      frac_o <= frac_i;
      n_o    <= n_i;
      big_o  <= big_i;
      acc_o  <= frac_i[BIT] ? prod[64:32] : acc_i;
    end
  end

endmodule

// ===== rtl/hier_fairshare_level_factor_unit.sv =====
// ---------------------------------------------------------------------------
// hier_fairshare_level_factor_unit: per-level fairshare factor
// Division chain for usage / adjusted shares, exponent chain for 2^-ratio,
// then bucket scaling and placement into the 64-bit priority word.
// ---------------------------------------------------------------------------
// Pipeline: (53 - FRAC_BITS) division cells, 32 exponent cells, then the scaling
// and output registers; each division cell yields one quotient bit.
// Throughput: one transaction per cycle; the whole chain advances together
// and holds only while a finished result is not taken.
// Reset: clears all stage valid bits and sets levels to 4.
// ---------------------------------------------------------------------------
module hier_fairshare_level_factor_unit
  import hfl_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        levels_we,
  input  logic [6:0]  levels,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] parent_word,
  input  logic [16:0] usage_eff,
  input  logic [16:0] shares,
  input  logic [5:0]  depth,
  input  logic        uses_parent,
  input  logic        is_user,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] packed_word,
  output logic [63:0] level_factor
);

  localparam int NUM_W = 53;
  localparam int Q_W   = NUM_W - FRAC_BITS;
  localparam int DEN_W = (FRAC_BITS > 20) ? FRAC_BITS + 2 : 22;

  logic [6:0] levels_r;
  logic       en;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      levels_r <= 7'd4;
    end else if (levels_we) begin
      levels_r <= levels;
    end
  end

  // whole chain moves unless the output register is stalled
  assign en       = out_ready | ~out_valid;
  assign in_ready = en;

  // entry: level geometry and divider operands
  logic [6:0]       lv;
  logic [6:0]       bw;
  logic [6:0]       spare;
  logic             contrib;
  logic             zero_ratio;
  logic [6:0]       lv_diff;
  logic [13:0]      sh_prod;
  logic [63:0]      bmax;
  logic [20:0]      usage10;
  logic [NUM_W-1:0] numer;
  logic [DEN_W-1:0] den;
  side_t            side_e;

  always_comb begin
    lv         = (levels_r > 7'd64) ? 7'd64 : levels_r;
    bw         = WIDTH_TAB[lv];
    spare      = SPARE_TAB[lv];
    contrib    = (lv != 7'd0) && ({1'b0, depth} < lv) && !(uses_parent && !is_user);
    zero_ratio = uses_parent || (shares == 17'd0) || !contrib;
    lv_diff    = lv - {1'b0, depth} - 7'd1;
    sh_prod    = 14'(lv_diff) * 14'(bw) + 14'(spare);
    bmax       = 64'hFFFF_FFFF_FFFF_FFFF >> (7'd64 - bw);
    usage10    = zero_ratio ? 21'd0 : (21'(usage_eff) << 3) + (21'(usage_eff) << 1);
    numer      = {usage10, 32'd0};
    den        = (DEN_W'(1) << FRAC_BITS) + (DEN_W'(shares) << 3) + DEN_W'(shares);
    side_e.parent  = parent_word;
    side_e.contrib = contrib;
    side_e.sh      = sh_prod[5:0];
    side_e.m       = bmax - 64'd1;
  end

  // division chain
  logic             dv   [Q_W+1];
  side_t            dside[Q_W+1];
  logic [DEN_W-1:0] dden [Q_W+1];
  logic [DEN_W-1:0] drem [Q_W+1];
  logic [Q_W-1:0]   dnum [Q_W+1];
  logic [Q_W-1:0]   dq   [Q_W+1];

  assign dv[0]    = in_valid;
  assign dside[0] = side_e;
  assign dden[0]  = den;
  assign drem[0]  = DEN_W'(numer[NUM_W-1:Q_W]);
  assign dnum[0]  = numer[Q_W-1:0];
  assign dq[0]    = '0;

  for (genvar i = 0; i < Q_W; i++) begin : g_div
    hfl_div_cell #(.DEN_W(DEN_W), .Q_W(Q_W)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .v_i(dv[i]), .side_i(dside[i]), .den_i(dden[i]), .rem_i(drem[i]),
      .num_i(dnum[i]), .q_i(dq[i]),
      .v_o(dv[i+1]), .side_o(dside[i+1]), .den_o(dden[i+1]), .rem_o(drem[i+1]),
      .num_o(dnum[i+1]), .q_o(dq[i+1])
    );
  end

  // ratio split into integer and fraction
  logic [63:0] ratio64;
  assign ratio64 = 64'(dq[Q_W]);

  // exponent chain
  logic        pv   [33];
  side_t       pside[33];
  logic [31:0] pfrac[33];
  logic [5:0]  pn   [33];
  logic        pbig [33];
  logic [32:0] pacc [33];

  assign pv[0]    = dv[Q_W];
  assign pside[0] = dside[Q_W];
  assign pfrac[0] = ratio64[31:0];
  assign pn[0]    = ratio64[37:32];
  assign pbig[0]  = ratio64[63:32] > 32'd32;
  assign pacc[0]  = 33'h1_0000_0000;

  for (genvar k = 0; k < 32; k++) begin : g_pow
    hfl_pow_cell #(.K(k + 1)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .v_i(pv[k]), .side_i(pside[k]), .frac_i(pfrac[k]), .n_i(pn[k]),
      .big_i(pbig[k]), .acc_i(pacc[k]),
      .v_o(pv[k+1]), .side_o(pside[k+1]), .frac_o(pfrac[k+1]), .n_o(pn[k+1]),
      .big_o(pbig[k+1]), .acc_o(pacc[k+1])
    );
  end

  // scaling stages: integer shift, low product, high product and sum
  logic        sv1, sv2, sv3;
  side_t       sside1, sside2, sside3;
  logic [32:0] f1, f2;
  logic [64:0] plo;
  logic [63:0] sum3;
  logic [65:0] phi;
  logic [63:0] factor;

  assign phi = 66'(f2) * 66'(sside2.m[63:32]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sv1       <= 1'b0;
      sv2       <= 1'b0;
      sv3       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      sv1       <= pv[32];
      sv2       <= sv1;
      sv3       <= sv2;
      out_valid <= sv3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sside1       <= pside[32];
      f1           <= pbig[32] ? 33'd0 : (pacc[32] >> pn[32]);
      sside2       <= sside1;
      f2           <= f1;
      plo          <= 65'(f1) * 65'(sside1.m[31:0]);
      sside3       <= sside2;
      sum3         <= phi[63:0] + 64'(plo[64:32]);
      packed_word  <= sside3.parent | factor;
      level_factor <= factor;
    end
  end

  // place the factor into this level's bucket
  assign factor = sside3.contrib ? ((sum3 + 64'd1) << sside3.sh) : 64'd0;

  // checks
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
  a_factor_in_word: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((packed_word & level_factor) == level_factor))
    else $error("level factor missing from packed word");
  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    pv[32] |-> (pacc[32] <= 33'h1_0000_0000))
    else $error("exponent accumulator above one");

endmodule

// ===== test/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: testbench for hier_fairshare_level_factor_unit
// Sends node transactions through a valid/ready driver over several level
// settings, predicts each level factor in fixed point, and compares the
// results field by field in arrival order.
// ---------------------------------------------------------------------------
module tb_top;
  import hfl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [63:0] parent;
    logic [16:0] usage;
    logic [16:0] shares;
    logic [5:0]  depth;
    logic        uses_parent;
    logic        is_user;
  } node_t;

  typedef struct {
    logic [63:0] packed_w;
    logic [63:0] factor;
  } word_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        levels_we = 0;
  logic [6:0]  levels = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [63:0] parent_word = 0;
  logic [16:0] usage_eff = 0;
  logic [16:0] shares = 0;
  logic [5:0]  depth = 0;
  logic        uses_parent = 0;
  logic        is_user = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [63:0] packed_word;
  logic [63:0] level_factor;

  node_t       node_q[$];
  word_t       word_q[$];
  node_t       cur;
  logic [6:0]  levels_cfg = 7'd4;
  logic [63:0] pow_c[1:32];
  int          errors = 0;
  int          cycles = 0;
  int          sent_cnt = 0;
  bit          taken = 0;
  bit          calm = 0;

  hier_fairshare_level_factor_unit #(.FRAC_BITS(FRAC)) dut (.*);

  always #1 clk = ~clk;

  // bitwise integer square root
  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // expected shifted factor of one node under a level count
  function automatic logic [63:0] factor_of(input node_t n, input logic [6:0] lv_raw);
    logic [63:0] lv;
    logic [63:0] w;
    logic [63:0] bmax;
    logic [63:0] m;
    logic [63:0] ratio;
    logic [63:0] den;
    logic [63:0] f;
    logic [63:0] sh;
    lv = (lv_raw > 64) ? 64 : lv_raw;
    if (lv == 0 || n.depth >= lv || (n.uses_parent && !n.is_user)) return 0;
    w = 64 / lv;
    bmax = {64{1'b1}} >> (64 - w);
    ratio = 0;
    if (!n.uses_parent && n.shares != 0) begin
      den = (64'd1 << FRAC) + 64'd9 * n.shares;
      ratio = ((64'd10 * n.usage) << 32) / den;
    end
    f = 64'd1 << 32;
    for (int k = 1; k <= 32; k++)
      if (ratio[32-k]) f = (f * pow_c[k]) >> 32;
    f = (ratio[63:32] > 32) ? 0 : f >> ratio[63:32];
    m = bmax - 1;
    f = f * (m >> 32) + ((f * (m & 64'hFFFF_FFFF)) >> 32) + 1;
    sh = (lv - n.depth - 1) * w + (64 % lv);
    return (sh < 64) ? f << sh : 0;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // monitor: accepted transactions, config writes, results
  always @(posedge clk) begin
    word_t e;
    cycles++;
    if (levels_we) levels_cfg = levels;
    if (!rst && in_valid && in_ready) begin
      e.factor = factor_of(cur, levels_cfg);
      e.packed_w = cur.parent | e.factor;
      word_q.push_back(e);
      taken = 1;
    end
    if (!rst && out_valid && out_ready) begin
      if (word_q.size() == 0) begin
        report("unexpected result", packed_word, 0);
      end else begin
        e = word_q.pop_front();
        if (packed_word !== e.packed_w) report("packed_word", packed_word, e.packed_w);
        if (level_factor !== e.factor) report("level_factor", level_factor, e.factor);
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycles);
      $display("hier_fairshare_level_factor_unit test failed");
      $finish;
    end
  end

  // driver: one node per accepted transaction, random gaps on both sides
  always @(negedge clk) begin
    bit    v_next;
    node_t n;
    v_next = in_valid;
    if (taken) begin
      v_next = 0;
      taken = 0;
      sent_cnt++;
    end
    if (!rst && !v_next && node_q.size() != 0 && (calm || $urandom_range(99) >= 34)) begin
      n = node_q.pop_front();
      cur = n;
      parent_word <= n.parent;
      usage_eff <= n.usage;
      shares <= n.shares;
      depth <= n.depth;
      uses_parent <= n.uses_parent;
      is_user <= n.is_user;
      v_next = 1;
    end
    in_valid <= v_next;
    out_ready <= calm || ($urandom_range(99) >= 34);
  end

  task automatic add_node(input logic [63:0] p, input logic [16:0] u, input logic [16:0] s,
                          input logic [5:0] d, input logic up, input logic usr);
    node_t n;
    n.parent = p;
    n.usage = u;
    n.shares = s;
    n.depth = d;
    n.uses_parent = up;
    n.is_user = usr;
    node_q.push_back(n);
  endtask

  // random node, mostly well-formed Q1.16 values at a live depth
  task automatic add_random(input int lv);
    logic [63:0] p;
    logic [16:0] u;
    logic [16:0] s;
    int          dmax;
    p = {$urandom, $urandom};
    if ($urandom_range(3) == 0) p = 0;
    u = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
    s = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
    if ($urandom_range(11) == 0) s = 0;
    if ($urandom_range(11) == 0) u = 0;
    if ($urandom_range(7) == 0) u = 17'($urandom_range(64));
    dmax = (lv > 64) ? 63 : (lv == 0 ? 0 : lv - 1);
    if (dmax > 63) dmax = 63;
    add_node(p, u, s,
             ($urandom_range(7) == 0) ? 6'($urandom) : 6'($urandom_range(dmax)),
             $urandom_range(7) == 0, $urandom_range(1));
  endtask

  // block until every queued node has gone and every result has come
  task automatic drain();
    while (node_q.size() != 0 || in_valid || word_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int lv_set[10] = '{1, 64, 0, 127, 7, 3, 2, 33, 5, 4};
    pow_c[1] = root64(64'd1 << 63);
    for (int k = 2; k <= 32; k++) pow_c[k] = root64(pow_c[k-1] << 32);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed nodes at the reset level count
    add_node(0, 0, 0, 0, 0, 0);
    add_node(0, 65536, 65536, 0, 0, 1);
    add_node({64{1'b1}}, 65536, 1, 1, 0, 0);
    add_node(64'hA5A5_5A5A_0F0F_F0F0, 17'h1FFFF, 17'h1FFFF, 2, 0, 1);
    add_node(0, 17'h1FFFF, 1, 3, 0, 0);
    add_node(0, 65536, 0, 3, 0, 1);
    add_node(0, 40000, 30000, 1, 1, 0);
    add_node(0, 40000, 30000, 1, 1, 1);
    add_node(64'h1234, 1, 65536, 3, 0, 0);
    add_node(0, 32768, 65536, 4, 0, 1);
    add_node(0, 32768, 65536, 63, 0, 1);
    add_node(0, 1, 17'h1FFFF, 2, 0, 0);
    add_node(0, 65535, 65535, 0, 0, 0);
    add_node(0, 6554, 0, 1, 1, 1);
    for (int i = 0; i < 150; i++) add_random(4);
    drain();

    foreach (lv_set[j]) begin
      @(negedge clk);
      levels <= 7'(lv_set[j]);
      levels_we <= 1;
      @(negedge clk);
      levels_we <= 0;
      add_node(0, 65536, 65536, 0, 0, 1);
      add_node({64{1'b1}}, 0, 0, 6'(lv_set[j] - 1), 0, 1);
      for (int i = 0; i < 150; i++) add_random(lv_set[j]);
      calm = (j == 4);
      drain();
      calm = 0;
    end

    if (errors == 0) begin
      $display("hier_fairshare_level_factor_unit test passed");
    end else begin
      $display("hier_fairshare_level_factor_unit test failed");
    end
    $finish;
  end
endmodule
